// ===== rtl/krpl_pkg.sv =====
`timescale 1ns / 1ps

package krpl_pkg;

    // Ring geometry and brightness scale
    localparam int RING_SIZE = 4;
    localparam int POS_W = 2;
    localparam int LEVEL_W = 8;
    localparam logic [LEVEL_W-1:0] FULL_BRIGHT = 8'd255;

    // Register map (word index = paddr[3:2])
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_FADE_STEP = 2'd0;
    localparam logic [1:0] REG_SENSITIVITY = 2'd1;
    localparam logic [1:0] REG_HOLD_POLLS = 2'd2;
    localparam logic [1:0] REG_SPEED_GAIN = 2'd3;

    typedef struct packed {
        logic [7:0]  fade_step;
        logic [6:0]  sensitivity;
        logic [15:0] hold_polls;
        logic [6:0]  speed_gain;
    } krpl_cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]   pos_first;
        logic [POS_W-1:0]   pos_second;
        logic [LEVEL_W-1:0] level_first;
        logic [LEVEL_W-1:0] level_second;
        logic [15:0]        hold_timer;
        logic [7:0]         fade_amount;
        logic signed [7:0]  motion_accum;
    } krpl_state_t;

    typedef struct packed {
        logic               lit;
        logic [POS_W-1:0]   first_position;
        logic [LEVEL_W-1:0] first_level;
        logic [POS_W-1:0]   second_position;
        logic [LEVEL_W-1:0] second_level;
    } krpl_result_t;

    // One position down / up around the ring
    function automatic logic [POS_W-1:0] pos_down(input logic [POS_W-1:0] p);
        pos_down = (p == '0) ? POS_W'(RING_SIZE - 1) : p - 1'b1;
    endfunction

    function automatic logic [POS_W-1:0] pos_up(input logic [POS_W-1:0] p);
        pos_up = (p == POS_W'(RING_SIZE - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ===== rtl/krpl_if.sv =====
`timescale 1ns / 1ps

interface krpl_knob_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] delta;

    modport source (output valid, output delta, input ready);
    modport sink (input valid, input delta, output ready);
endinterface

interface krpl_ring_if;
    logic       valid;
    logic       ready;
    logic       lit;
    logic [1:0] first_position;
    logic [7:0] first_level;
    logic [1:0] second_position;
    logic [7:0] second_level;

    modport source (output valid, output lit, output first_position, output first_level,
                    output second_position, output second_level, input ready);
    modport sink (input valid, input lit, input first_position, input first_level,
                  input second_position, input second_level, output ready);
endinterface

// ===== rtl/krpl_step.sv =====
`timescale 1ns / 1ps

module krpl_step
    import krpl_pkg::*;
(
    input  krpl_cfg_t         cfg,
    input  krpl_state_t       state,
    input  logic signed [7:0] delta,
    output krpl_state_t       state_next,
    output krpl_result_t      result
);

    logic signed [8:0]  accum_sum;
    logic signed [8:0]  accum_sat;
    logic signed [8:0]  sens_s;
    logic signed [15:0] prod;
    logic signed [7:0]  step;
    logic [7:0]         mag;
    logic [8:0]         fade_limit;

    always_comb
    begin
        accum_sum = 9'(state.motion_accum) + 9'(delta);
        if (accum_sum > 9'sd127)
            accum_sat = 9'sd127;
        else if (accum_sum < -9'sd127)
            accum_sat = -9'sd127;
        else
            accum_sat = accum_sum;

        sens_s = $signed({2'b00, cfg.sensitivity});

        prod = 16'(delta) * 16'($signed({1'b0, cfg.speed_gain}));
        if (prod > 16'sd127)
            step = 8'sd127;
        else if (prod < -16'sd127)
            step = -8'sd127;
        else
            step = 8'(prod);
        mag = 8'(-step);

        fade_limit = {1'b0, FULL_BRIGHT} - {1'b0, cfg.fade_step};

        state_next = state;
        if (delta == 8'sd0)
        begin
            // idle poll: run down the hold, then fade out
            if (state.hold_timer != '0)
            begin
                state_next.hold_timer = state.hold_timer - 1'b1;
                if (state.hold_timer == 16'd1)
                    state_next.motion_accum = '0;
            end
            else if ({1'b0, state.fade_amount} < fade_limit)
                state_next.fade_amount = state.fade_amount + cfg.fade_step;
            else
                state_next.fade_amount = FULL_BRIGHT;
        end
        else
        begin
            state_next.motion_accum = 8'(accum_sat);
            if (state.hold_timer != '0 || accum_sat > sens_s || accum_sat < -sens_s)
            begin
                state_next.hold_timer = cfg.hold_polls;
                state_next.fade_amount = '0;
            end

            if (step > 8'sd0)
            begin
                if (8'(step) > state.level_second)
                begin
                    state_next.level_first = '0;
                    state_next.level_second = FULL_BRIGHT;
                    state_next.pos_second = state.pos_first;
                    state_next.pos_first = pos_down(state.pos_first);
                end
                else
                begin
                    state_next.level_first = state.level_first + 8'(step);
                    state_next.level_second = state.level_second - 8'(step);
                end
            end
            else if (step < 8'sd0)
            begin
                if (mag > state.level_first)
                begin
                    state_next.level_first = FULL_BRIGHT;
                    state_next.level_second = '0;
                    state_next.pos_first = state.pos_second;
                    state_next.pos_second = pos_up(state.pos_second);
                end
                else
                begin
                    state_next.level_first = state.level_first - mag;
                    state_next.level_second = state.level_second + mag;
                end
            end
        end

        result.lit = (state_next.fade_amount < FULL_BRIGHT);
        result.first_position = state_next.pos_first;
        result.second_position = state_next.pos_second;
        result.first_level = (state_next.fade_amount > state_next.level_first) ? '0 :
                             state_next.level_first - state_next.fade_amount;
        result.second_level = (state_next.fade_amount > state_next.level_second) ? '0 :
                              state_next.level_second - state_next.fade_amount;
    end

endmodule

// ===== rtl/knob_ring_position_light_unit.sv =====
`timescale 1ns / 1ps

// Knob ring position light. Each word on the knob channel is one poll: a
// signed delta, zero for an idle poll. Each poll gives exactly one word on
// the ring channel, holding the lit flag, the two adjacent ring positions and
// their levels after the fade-out has been taken off (floored at zero). The
// path is two registers deep: a poll waits in the input register until the
// output register is free, then the step logic (one 8x8 multiply, saturation
// and compares) updates the state and loads the output register. A new poll
// is taken every cycle as long as the ring side keeps up; a stalled output
// word blocks at most the one poll held in the input register. Registers sit
// on the APB port at byte addresses 0x0 fade_step, 0x4 sensitivity, 0x8
// hold_polls, 0xC speed_gain; write them only while no poll is in flight.

module knob_ring_position_light_unit
    import krpl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    krpl_knob_if.sink          knob,
    krpl_ring_if.source        ring,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    krpl_cfg_t         cfg_reg;
    krpl_state_t       state_reg;
    krpl_state_t       state_next;
    krpl_result_t      result_next;
    krpl_result_t      result_reg;
    logic              in_valid_reg;
    logic signed [7:0] delta_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              cfg_write;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fade_step <= 8'd8;
            cfg_reg.sensitivity <= 7'd10;
            cfg_reg.hold_polls <= 16'd500;
            cfg_reg.speed_gain <= 7'd8;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_FADE_STEP:   cfg_reg.fade_step <= pwdata[7:0];
                REG_SENSITIVITY: cfg_reg.sensitivity <= pwdata[6:0];
                REG_HOLD_POLLS:  cfg_reg.hold_polls <= pwdata[15:0];
                REG_SPEED_GAIN:  cfg_reg.speed_gain <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FADE_STEP:   prdata = {24'd0, cfg_reg.fade_step};
            REG_SENSITIVITY: prdata = {25'd0, cfg_reg.sensitivity};
            REG_HOLD_POLLS:  prdata = {16'd0, cfg_reg.hold_polls};
            REG_SPEED_GAIN:  prdata = {25'd0, cfg_reg.speed_gain};
            default:         prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    // The poll in the input register moves into the output register when
    // that one is empty or being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || ring.ready);
    assign knob.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (knob.ready)
                in_valid_reg <= knob.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (ring.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (knob.valid && knob.ready)
            delta_reg <= knob.delta;
        if (advance)
            result_reg <= result_next;
    end

    // ---------------- step logic and state ----------------
    krpl_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .delta      (delta_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pos_first <= POS_W'(2 % RING_SIZE);
            state_reg.pos_second <= POS_W'(3 % RING_SIZE);
            state_reg.level_first <= FULL_BRIGHT;
            state_reg.level_second <= '0;
            state_reg.hold_timer <= '0;
            state_reg.fade_amount <= '0;
            state_reg.motion_accum <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign ring.valid = out_valid_reg;
    assign ring.lit = result_reg.lit;
    assign ring.first_position = result_reg.first_position;
    assign ring.first_level = result_reg.first_level;
    assign ring.second_position = result_reg.second_position;
    assign ring.second_level = result_reg.second_level;

    // ---------------- assertions ----------------
    // the two levels always crossfade: their sum is full brightness
    a_level_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, state_reg.level_first} + {1'b0, state_reg.level_second})
            == {1'b0, FULL_BRIGHT})
        else $error("ring levels do not sum to full brightness");

    // the lit pair stays adjacent on the ring
    a_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pos_second == pos_up(state_reg.pos_first))
        else $error("ring positions not adjacent");

    // fading only happens once the hold has run out
    a_fade_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.fade_amount != '0 |-> state_reg.hold_timer == '0)
        else $error("fade active while hold timer running");

    // state moves only when a poll is handed to the output register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a poll");

endmodule
